@@ rtl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// Shared constants and codes for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

  // Default coordinate width in bits.
  localparam int COORD_BITS_DEFAULT = 16;

  // APB address width: five registers at byte addresses 0, 4, ... 16.
  localparam int PADDR_BITS = 5;
  localparam int REG_IDX_BITS = 3;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_WINDOW_WIDTH   = 3'd0,
    REG_WINDOW_HEIGHT  = 3'd1,
    REG_FRAME_BASE     = 3'd2,
    REG_ROW_BYTES      = 3'd3,
    REG_BITS_PER_PIXEL = 3'd4
  } cfg_reg_t;

  // Command codes.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Register reset values.
  localparam logic [14:0] WINDOW_WIDTH_RESET   = 15'd1920;
  localparam logic [14:0] WINDOW_HEIGHT_RESET  = 15'd1080;
  localparam logic [31:0] FRAME_BASE_RESET     = 32'd0;
  localparam logic [15:0] ROW_BYTES_RESET      = 16'd7680;
  localparam logic [5:0]  BITS_PER_PIXEL_RESET = 6'd32;

endpackage

@@ rtl/bls_if.sv @@
// ----------------------------------------------------------------------------
// bls_cmd_if / bls_pixel_if
// Valid/ready channels for line commands and plotted pixels.
// ----------------------------------------------------------------------------
interface bls_cmd_if #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [31:0]                  pixel_color;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, pixel_color,
                  input ready);
  modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, pixel_color,
                  output ready);
endinterface

interface bls_pixel_if #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic                         pixel_write;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [31:0]                  pixel_address;
  logic [31:0]                  write_color;
  logic                         line_done;

  modport source (output valid, pixel_write, pixel_x, pixel_y, pixel_address,
                  write_color, line_done, input ready);
  modport sink   (input valid, pixel_write, pixel_x, pixel_y, pixel_address,
                  write_color, line_done, output ready);
endinterface

@@ rtl/bresenham_line_stepper.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer Bresenham line rasteriser producing one framebuffer pixel per step.
// ----------------------------------------------------------------------------
//
//   Channel     Dir  Handshake          Contents
//   cmd_chan    in   valid/ready        cmd, endpoints, pixel_color
//   pixel_chan  out  valid/ready        write flag, point, address, colour, done
//   APB         in   psel/penable       window, frame base, row pitch, bpp
//
// Every command transaction produces exactly one pixel transaction. A command
// is processed in the cycle it is accepted, and its result is registered, so
// the block sustains one transaction per clock until both result entries are
// full. The rate is set by the single state update loop (one add and compare
// on the decision term) and the address multiply, both combinational.
// A two-entry result buffer (output register plus skid register) lets a
// command be accepted while a result is still waiting; ready drops only once
// both entries are full. Synchronous active-high reset empties the buffer,
// clears the line state and loads the register defaults.
// ----------------------------------------------------------------------------
module bresenham_line_stepper #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  bls_cmd_if.sink                         cmd_chan,
  bls_pixel_if.source                     pixel_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bls_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int W    = COORD_BITS;
  // The decision term stays within a few times the major length.
  localparam int DW   = W + 4;
  // Compare width wide enough for both a coordinate and a 15-bit window size.
  localparam int CMPW = ((W > 15) ? W : 15) + 1;

  // One result as it sits in the output buffer.
  typedef struct packed {
    logic                pixel_write;
    logic signed [W-1:0] pixel_x;
    logic signed [W-1:0] pixel_y;
    logic [31:0]         pixel_address;
    logic [31:0]         write_color;
    logic                line_done;
  } result_t;

  // Configuration registers.
  logic [14:0] window_width;
  logic [14:0] window_height;
  logic [31:0] frame_base;
  logic [15:0] row_bytes;
  logic [5:0]  bits_per_pixel;

  // Line state.
  logic signed [W-1:0]  cur_x, cur_y, goal_x, goal_y;
  logic signed [DW-1:0] decision;
  logic [W+1:0]         add_straight;
  logic signed [W+1:0]  add_diagonal;
  logic                 x_major;
  logic [31:0]          line_color;
  logic                 line_active;

  logic signed [W-1:0]  cur_x_next, cur_y_next, goal_x_next, goal_y_next;
  logic signed [DW-1:0] decision_next;
  logic [W+1:0]         add_straight_next;
  logic signed [W+1:0]  add_diagonal_next;
  logic                 x_major_next;
  logic [31:0]          line_color_next;
  logic                 line_active_next;

  // Output buffer.
  result_t head, skid, res_new;
  logic    head_valid, skid_valid;
  logic    accept, pop;

  // Start-of-line set-up terms.
  logic signed [W:0] dx_s, dy_s;
  logic [W:0]        dx_abs, dy_abs, major, minor, minor_less_major;

  // Per-step terms.
  logic [31:0]          ux, uy, row_term, pix_term, step_address;
  logic                 in_window;
  logic signed [DW-1:0] straight_ext, diag_ext;
  logic                 go_straight;
  logic signed [W-1:0]  moved_x, moved_y;
  logic                 step_done;

  // Move a coordinate one pixel towards its goal, wrapping at the coordinate
  // width.
  function automatic logic signed [W-1:0] toward(input logic signed [W-1:0] c,
                                                 input logic signed [W-1:0] g);
    toward = (c < g) ? W'(c + 1) : W'(c - 1);
  endfunction

  // --------------------------------------------------------------------------
  // APB register file. pready is tied high, so a write lands on the access
  // cycle. Addresses beyond the register list are ignored and read as zero.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width   <= bls_pkg::WINDOW_WIDTH_RESET;
      window_height  <= bls_pkg::WINDOW_HEIGHT_RESET;
      frame_base     <= bls_pkg::FRAME_BASE_RESET;
      row_bytes      <= bls_pkg::ROW_BYTES_RESET;
      bits_per_pixel <= bls_pkg::BITS_PER_PIXEL_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        bls_pkg::REG_WINDOW_WIDTH:   window_width   <= pwdata[14:0];
        bls_pkg::REG_WINDOW_HEIGHT:  window_height  <= pwdata[14:0];
        bls_pkg::REG_FRAME_BASE:     frame_base     <= pwdata;
        bls_pkg::REG_ROW_BYTES:      row_bytes      <= pwdata[15:0];
        bls_pkg::REG_BITS_PER_PIXEL: bits_per_pixel <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      bls_pkg::REG_WINDOW_WIDTH:   prdata = {17'd0, window_width};
      bls_pkg::REG_WINDOW_HEIGHT:  prdata = {17'd0, window_height};
      bls_pkg::REG_FRAME_BASE:     prdata = frame_base;
      bls_pkg::REG_ROW_BYTES:      prdata = {16'd0, row_bytes};
      bls_pkg::REG_BITS_PER_PIXEL: prdata = {26'd0, bits_per_pixel};
      default:                     prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake. The buffer has room unless the skid register is occupied.
  // --------------------------------------------------------------------------
  assign cmd_chan.ready = !skid_valid;
  assign accept         = cmd_chan.valid && !skid_valid;
  assign pop            = head_valid && pixel_chan.ready;

  // --------------------------------------------------------------------------
  // Line set-up: absolute deltas with one spare bit, so that a full-range
  // span of up to two to the coordinate width minus one is held exactly.
  // --------------------------------------------------------------------------
  always_comb begin
    dx_s   = (W+1)'(cmd_chan.x_end) - (W+1)'(cmd_chan.x_start);
    dy_s   = (W+1)'(cmd_chan.y_end) - (W+1)'(cmd_chan.y_start);
    dx_abs = dx_s[W] ? $unsigned(-dx_s) : $unsigned(dx_s);
    dy_abs = dy_s[W] ? $unsigned(-dy_s) : $unsigned(dy_s);
    major  = (dx_abs >= dy_abs) ? dx_abs : dy_abs;
    minor  = (dx_abs >= dy_abs) ? dy_abs : dx_abs;
    // Never positive and no smaller than minus two to the coordinate width.
    minor_less_major = minor - major;
  end

  // --------------------------------------------------------------------------
  // Step terms, taken from the current point before it moves.
  // --------------------------------------------------------------------------
  always_comb begin
    ux       = 32'(cur_x);
    uy       = 32'(cur_y);
    row_term = uy * {16'd0, row_bytes};
    pix_term = ux * {29'd0, bits_per_pixel[5:3]};
    step_address = frame_base + row_term + pix_term;

    in_window = !cur_x[W-1] && !cur_y[W-1] &&
                (CMPW'($unsigned(cur_x)) < CMPW'(window_width)) &&
                (CMPW'($unsigned(cur_y)) < CMPW'(window_height));

    straight_ext = $signed({2'b00, add_straight});
    diag_ext     = {{2{add_diagonal[W+1]}}, add_diagonal};
    go_straight  = decision[DW-1];

    // The minor axis moves only on a diagonal step.
    if (x_major) begin
      moved_y   = go_straight ? cur_y : toward(cur_y, goal_y);
      moved_x   = toward(cur_x, goal_x);
      step_done = (moved_x == goal_x);
    end else begin
      moved_x   = go_straight ? cur_x : toward(cur_x, goal_x);
      moved_y   = toward(cur_y, goal_y);
      step_done = (moved_y == goal_y);
    end
  end

  // --------------------------------------------------------------------------
  // Next line state and the result of the command on offer.
  // --------------------------------------------------------------------------
  always_comb begin
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    goal_x_next       = goal_x;
    goal_y_next       = goal_y;
    decision_next     = decision;
    add_straight_next = add_straight;
    add_diagonal_next = add_diagonal;
    x_major_next      = x_major;
    line_color_next   = line_color;
    line_active_next  = line_active;

    res_new.pixel_write   = 1'b0;
    res_new.pixel_x       = cur_x;
    res_new.pixel_y       = cur_y;
    res_new.pixel_address = 32'd0;
    res_new.write_color   = 32'd0;
    res_new.line_done     = 1'b1;

    if (cmd_chan.cmd == bls_pkg::CMD_START) begin
      cur_x_next        = cmd_chan.x_start;
      cur_y_next        = cmd_chan.y_start;
      goal_x_next       = cmd_chan.x_end;
      goal_y_next       = cmd_chan.y_end;
      line_color_next   = cmd_chan.pixel_color;
      x_major_next      = (dx_abs >= dy_abs);
      add_straight_next = {minor, 1'b0};
      add_diagonal_next = {minor_less_major, 1'b0};
      decision_next     = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
      // A zero-length line never becomes active.
      line_active_next  = (major != '0);

      res_new.pixel_x   = cmd_chan.x_start;
      res_new.pixel_y   = cmd_chan.y_start;
      res_new.line_done = (major == '0);
    end else if (line_active) begin
      cur_x_next       = moved_x;
      cur_y_next       = moved_y;
      decision_next    = decision + (go_straight ? straight_ext : diag_ext);
      line_active_next = !step_done;

      // A clipped point still reports its address and colour.
      res_new.pixel_write   = in_window;
      res_new.pixel_address = step_address;
      res_new.write_color   = line_color;
      res_new.line_done     = step_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      goal_x       <= '0;
      goal_y       <= '0;
      decision     <= '0;
      add_straight <= '0;
      add_diagonal <= '0;
      x_major      <= 1'b1;
      line_color   <= 32'd0;
      line_active  <= 1'b0;
    end else if (accept) begin
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      goal_x       <= goal_x_next;
      goal_y       <= goal_y_next;
      decision     <= decision_next;
      add_straight <= add_straight_next;
      add_diagonal <= add_diagonal_next;
      x_major      <= x_major_next;
      line_color   <= line_color_next;
      line_active  <= line_active_next;
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry result buffer. The head drives the output; the skid register
  // catches a result accepted while the head is stalled.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= accept;
      end else begin
        head_valid <= accept;
      end
    end else if (!head_valid) begin
      head_valid <= accept;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        skid <= res_new;
      end else begin
        head <= res_new;
      end
    end else if (!head_valid) begin
      head <= res_new;
    end else if (accept) begin
      skid <= res_new;
    end
  end

  assign pixel_chan.valid         = head_valid;
  assign pixel_chan.pixel_write   = head.pixel_write;
  assign pixel_chan.pixel_x       = head.pixel_x;
  assign pixel_chan.pixel_y       = head.pixel_y;
  assign pixel_chan.pixel_address = head.pixel_address;
  assign pixel_chan.write_color   = head.write_color;
  assign pixel_chan.line_done     = head.line_done;

endmodule

@@ rtl/bls_checker.sv @@
// ----------------------------------------------------------------------------
// bls_checker
// Port-level assertions for the Bresenham line stepper, bound to its top.
// ----------------------------------------------------------------------------
module bls_checker #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         pixel_valid,
  input logic                         pixel_ready,
  input logic                         pixel_write,
  input logic signed [COORD_BITS-1:0] pixel_x,
  input logic signed [COORD_BITS-1:0] pixel_y,
  input logic [31:0]                  pixel_address,
  input logic [31:0]                  write_color,
  input logic                         line_done
);

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel transaction pending after reset");

  // With no result pending the block must take a command.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !pixel_valid |-> cmd_ready)
    else $error("command stalled with an empty result buffer");

  // Every accepted command leaves a result pending on the next cycle.
  a_cmd_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> pixel_valid)
    else $error("accepted command produced no pixel transaction");

  // A stalled result holds its contents.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid &&
      $stable({pixel_write, pixel_x, pixel_y, pixel_address, write_color, line_done}))
    else $error("stalled pixel transaction changed");

  // A written pixel never has a negative coordinate.
  a_write_in_window: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_write |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
    else $error("pixel written at a negative coordinate");

endmodule

bind bresenham_line_stepper bls_checker #(.COORD_BITS(COORD_BITS)) u_bls_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd_chan.valid),
  .cmd_ready     (cmd_chan.ready),
  .pixel_valid   (pixel_chan.valid),
  .pixel_ready   (pixel_chan.ready),
  .pixel_write   (pixel_chan.pixel_write),
  .pixel_x       (pixel_chan.pixel_x),
  .pixel_y       (pixel_chan.pixel_y),
  .pixel_address (pixel_chan.pixel_address),
  .write_color   (pixel_chan.write_color),
  .line_done     (pixel_chan.line_done)
);
